>>> hw/rtl/eabb_pkg.sv
// eabb_pkg: shared constants, register codes and the reciprocal table of the
// 3x3 box filter. Depends on nothing; used by the interfaces, the RAM and the top level.
`default_nettype none

package eabb_pkg;

    // default geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // pixel and configuration widths
    localparam int PIXEL_W        = 8;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_SIZE_RESET = 1024;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // neighbourhood sum and count widths
    localparam int NBR_MAX   = 9;
    localparam int SUM_W     = $clog2(NBR_MAX * ((1 << PIXEL_W) - 1) + 1);
    localparam int CNT_W     = $clog2(NBR_MAX + 1);
    // shift of the reciprocal: exact quotient for every sum below 2**SUM_W
    localparam int REC_SHIFT = SUM_W + CNT_W;
    localparam int REC_W     = REC_SHIFT + 1;
    localparam int PROD_W    = SUM_W + REC_W;

    // ceil(2**16 / cnt), zero for an empty neighbourhood
    function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [REC_W-1:0] r;
        case (cnt)
            4'd1:    r = REC_W'(65536);
            4'd2:    r = REC_W'(32768);
            4'd3:    r = REC_W'(21846);
            4'd4:    r = REC_W'(16384);
            4'd5:    r = REC_W'(13108);
            4'd6:    r = REC_W'(10923);
            4'd7:    r = REC_W'(9363);
            4'd8:    r = REC_W'(8192);
            4'd9:    r = REC_W'(7282);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/eabb_pix_if.sv
// eabb_pix_if: pixel input channel (valid, ready, pixel_value, blank_tick).
// Depends on eabb_pkg for the pixel width.
`default_nettype none

interface eabb_pix_if;
    logic                         valid;
    logic                         ready;
    logic [eabb_pkg::PIXEL_W-1:0] pixel_value;
    logic                         blank_tick;

    modport source (output valid, output pixel_value, output blank_tick, input ready);
    modport sink   (input valid, input pixel_value, input blank_tick, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/eabb_res_if.sv
// eabb_res_if: result channel (valid, ready, smoothed_value, row_end, frame_end).
// Depends on eabb_pkg for the pixel width.
`default_nettype none

interface eabb_res_if;
    logic                         valid;
    logic                         ready;
    logic [eabb_pkg::PIXEL_W-1:0] smoothed_value;
    logic                         row_end;
    logic                         frame_end;

    modport source (output valid, output smoothed_value, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input smoothed_value, input row_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/eabb_ram.sv
// eabb_ram: generic single-clock RAM, one write port and one read port,
// registered read data. Depends on eabb_pkg for its default sizes.
`default_nettype none

module eabb_ram #(
    parameter int WIDTH = eabb_pkg::PIXEL_W,
    parameter int DEPTH = eabb_pkg::MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/edge_aware_box_blur_3x3_top.sv
// edge_aware_box_blur_3x3_top: streaming 3x3 mean filter over two line-store RAMs.
// Depends on eabb_pkg, eabb_pix_if, eabb_res_if and eabb_ram.
// Timing: the beat that causes a result is the beat one row plus one pixel later in raster
//   order; it passes through ST_READ, ST_CALC, ST_MUL and ST_OUT, and the result is loaded
//   into the output register from ST_OUT, later while it still holds an untaken beat.
// A beat that yields no result returns to ST_IDLE after ST_CALC; an ignored blank beat
//   leaves the FSM in ST_IDLE. One beat is in flight at a time: the input is ready only in
//   ST_IDLE, after the line-store read, write-back and the reciprocal multiply are through.
// Reset (rst_n, asynchronous): counters, window and fill count to zero, sizes to 1024,
//   output empty; line-store entries not written since reset read as zero.
`default_nettype none

module edge_aware_box_blur_3x3_top #(
    parameter int MAX_WIDTH  = eabb_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = eabb_pkg::MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    eabb_pix_if.sink                       pixel,
    eabb_res_if.source                     result,
    input  logic                           cfg_wr_en,
    input  logic [eabb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eabb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = COL_W + 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 4);
    localparam int PIX_W  = eabb_pkg::PIXEL_W;
    localparam int SUM_W  = eabb_pkg::SUM_W;
    localparam int CNT_W  = eabb_pkg::CNT_W;
    localparam int PROD_W = eabb_pkg::PROD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [eabb_pkg::CFG_W-1:0] cfg_width_reg, cfg_width_next;
    logic [eabb_pkg::CFG_W-1:0] cfg_height_reg, cfg_height_next;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    // line-store fill count: entries below it have been written since reset
    logic [W_W-1:0]   fill_reg, fill_next;
    logic             rd_known_reg, rd_known_next;

    logic [PIX_W-1:0]            pix_reg, pix_next;
    logic [2:0][2:0][PIX_W-1:0]  win_reg, win_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        row_end_reg, row_end_next;
    logic                        frame_end_reg, frame_end_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;

    logic             res_valid_reg, res_valid_next;
    logic [PIX_W-1:0] res_value_reg, res_value_next;
    logic             res_row_end_reg, res_row_end_next;
    logic             res_frame_end_reg, res_frame_end_next;

    logic [W_W-1:0]   w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             pix_beat;
    logic             flushing;

    logic [PIX_W-1:0]           upper_rd, lower_rd;
    logic [PIX_W-1:0]           upper_val, lower_val;
    logic [2:0][PIX_W-1:0]      col_new;
    logic [2:0]                 row_ok, col_ok;
    logic [2:0][SUM_W-1:0]      row_sum;
    logic [SUM_W-1:0]           nbr_sum;
    logic [CNT_W-1:0]           nbr_cnt;
    logic                       ic_zero;
    logic                       emit;
    logic                       col_last;
    logic                       row_last;
    logic [W_W-1:0]             oc_ext;
    logic [ROW_W:0]             or_ext;

    // sizes in use: zero reads as one, above the maximum as the maximum
    always_comb
    begin
        if (cfg_width_reg == '0)
            w_eff = W_W'(1);
        else if (32'(cfg_width_reg) > MAX_WIDTH)
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(cfg_width_reg);

        if (cfg_height_reg == '0)
            h_eff = ROW_W'(1);
        else if (32'(cfg_height_reg) > MAX_HEIGHT)
            h_eff = ROW_W'(MAX_HEIGHT);
        else
            h_eff = ROW_W'(cfg_height_reg);
    end

    // line stores: row two above and row one above the incoming pixel
    eabb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_CALC),
        .wr_addr (in_col_reg),
        .wr_data (lower_val),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (in_col_reg),
        .rd_data (upper_rd)
    );

    eabb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_CALC),
        .wr_addr (in_col_reg),
        .wr_data (pix_reg),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (in_col_reg),
        .rd_data (lower_rd)
    );

    // entries at or beyond the fill count read as zero
    assign upper_val = rd_known_reg ? upper_rd : '0;
    assign lower_val = rd_known_reg ? lower_rd : '0;

    assign pixel.ready = (state_reg == ST_IDLE);
    assign pix_beat    = pixel.valid && pixel.ready;
    assign flushing    = (in_row_reg >= h_eff) && (out_row_reg < h_eff);

    // neighbourhood of the output position
    // left neighbour sits in window column 1 and centre in column 2 before the shift;
    // the right neighbour is the new column and exists only away from input column 0
    always_comb
    begin
        ic_zero    = (in_col_reg == '0);
        emit       = ((in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && !ic_zero))
                     && (out_row_reg < h_eff);
        col_new[0] = upper_val;
        col_new[1] = lower_val;
        col_new[2] = pix_reg;
        oc_ext     = {1'b0, out_col_reg};
        or_ext     = {1'b0, out_row_reg};

        col_ok[0]  = (out_col_reg != '0) && ((oc_ext - W_W'(1)) < w_eff);
        col_ok[1]  = oc_ext < w_eff;
        col_ok[2]  = !ic_zero && ((oc_ext + W_W'(1)) < w_eff);
        row_ok[0]  = (out_row_reg != '0) && ((or_ext - (ROW_W+1)'(1)) < {1'b0, h_eff});
        row_ok[1]  = or_ext < {1'b0, h_eff};
        row_ok[2]  = (or_ext + (ROW_W+1)'(1)) < {1'b0, h_eff};

        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = (col_ok[0] ? SUM_W'(win_reg[r][1]) : '0)
                       + (col_ok[1] ? SUM_W'(win_reg[r][2]) : '0)
                       + (col_ok[2] ? SUM_W'(col_new[r])    : '0);
        end
        nbr_sum = (row_ok[0] ? row_sum[0] : '0)
                + (row_ok[1] ? row_sum[1] : '0)
                + (row_ok[2] ? row_sum[2] : '0);
        nbr_cnt = CNT_W'($countones(row_ok)) * CNT_W'($countones(col_ok));

        col_last = (oc_ext + W_W'(1)) >= w_eff;
        row_last = (or_ext + (ROW_W+1)'(1)) >= {1'b0, h_eff};
    end

    // next-state logic
    always_comb
    begin
        state_next         = state_reg;
        cfg_width_next     = cfg_width_reg;
        cfg_height_next    = cfg_height_reg;
        in_col_next        = in_col_reg;
        in_row_next        = in_row_reg;
        out_col_next       = out_col_reg;
        out_row_next       = out_row_reg;
        fill_next          = fill_reg;
        rd_known_next      = rd_known_reg;
        pix_next           = pix_reg;
        win_next           = win_reg;
        sum_next           = sum_reg;
        cnt_next           = cnt_reg;
        row_end_next       = row_end_reg;
        frame_end_next     = frame_end_reg;
        prod_next          = prod_reg;
        res_valid_next     = res_valid_reg;
        res_value_next     = res_value_reg;
        res_row_end_next   = res_row_end_reg;
        res_frame_end_next = res_frame_end_reg;

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                eabb_pkg::CFG_IMAGE_WIDTH:  cfg_width_next  = cfg_data;
                eabb_pkg::CFG_IMAGE_HEIGHT: cfg_height_next = cfg_data;
                default: ;
            endcase
        end

        // output register drains on a taken beat
        if (result.valid && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_beat)
                begin
                    if (pixel.blank_tick)
                    begin
                        // blank beat only advances while a flush is pending
                        if (flushing)
                        begin
                            pix_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        pix_next   = pixel.pixel_value;
                        state_next = ST_READ;
                        // pixel after the last row starts a new frame
                        if (in_row_reg >= h_eff)
                        begin
                            in_col_next  = '0;
                            in_row_next  = '0;
                            out_col_next = '0;
                            out_row_next = '0;
                        end
                    end
                    if (state_next == ST_READ && 32'(in_col_next) >= MAX_WIDTH)
                    begin
                        in_col_next = '0;
                    end
                end
            end

            ST_READ:
            begin
                // note whether the entry being read has been written since reset
                rd_known_next = ({1'b0, in_col_reg} < fill_reg);
                state_next    = ST_CALC;
            end

            ST_CALC:
            begin
                // neighbourhood sum and count for the result, if one is due
                sum_next       = nbr_sum;
                cnt_next       = nbr_cnt;
                row_end_next   = col_last;
                frame_end_next = col_last && row_last;
                if (emit)
                begin
                    if (col_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end

                // write-back extends the written prefix of the line stores
                if ({1'b0, in_col_reg} == fill_reg)
                begin
                    fill_next = fill_reg + W_W'(1);
                end

                // window shift by one column
                for (int r = 0; r < 3; r++)
                begin
                    win_next[r][0] = win_reg[r][1];
                    win_next[r][1] = win_reg[r][2];
                    win_next[r][2] = col_new[r];
                end

                // input position advance
                if (({1'b0, in_col_reg} + W_W'(1)) >= w_eff)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end

                state_next = emit ? ST_MUL : ST_IDLE;
            end

            ST_MUL:
            begin
                // floor(sum / count) by reciprocal multiply
                prod_next  = PROD_W'(sum_reg) * PROD_W'(eabb_pkg::recip(cnt_reg));
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next     = 1'b1;
                    res_value_next     = prod_reg[eabb_pkg::REC_SHIFT +: PIX_W];
                    res_row_end_next   = row_end_reg;
                    res_frame_end_next = frame_end_reg;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cfg_width_reg     <= eabb_pkg::CFG_W'(eabb_pkg::CFG_SIZE_RESET);
            cfg_height_reg    <= eabb_pkg::CFG_W'(eabb_pkg::CFG_SIZE_RESET);
            in_col_reg        <= '0;
            in_row_reg        <= '0;
            out_col_reg       <= '0;
            out_row_reg       <= '0;
            fill_reg          <= '0;
            rd_known_reg      <= 1'b0;
            pix_reg           <= '0;
            win_reg           <= '0;
            sum_reg           <= '0;
            cnt_reg           <= '0;
            row_end_reg       <= 1'b0;
            frame_end_reg     <= 1'b0;
            prod_reg          <= '0;
            res_valid_reg     <= 1'b0;
            res_value_reg     <= '0;
            res_row_end_reg   <= 1'b0;
            res_frame_end_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cfg_width_reg     <= cfg_width_next;
            cfg_height_reg    <= cfg_height_next;
            in_col_reg        <= in_col_next;
            in_row_reg        <= in_row_next;
            out_col_reg       <= out_col_next;
            out_row_reg       <= out_row_next;
            fill_reg          <= fill_next;
            rd_known_reg      <= rd_known_next;
            pix_reg           <= pix_next;
            win_reg           <= win_next;
            sum_reg           <= sum_next;
            cnt_reg           <= cnt_next;
            row_end_reg       <= row_end_next;
            frame_end_reg     <= frame_end_next;
            prod_reg          <= prod_next;
            res_valid_reg     <= res_valid_next;
            res_value_reg     <= res_value_next;
            res_row_end_reg   <= res_row_end_next;
            res_frame_end_reg <= res_frame_end_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.smoothed_value = res_value_reg;
    assign result.row_end        = res_row_end_reg;
    assign result.frame_end      = res_frame_end_reg;

endmodule

`default_nettype wire

>>> hw/rtl/eabb_checker.sv
// eabb_checker: port-level assertions for the 3x3 box filter, bound to the top level.
// Depends on eabb_pkg and edge_aware_box_blur_3x3_top.
`default_nettype none

module eabb_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         pix_valid,
    input wire logic                         pix_ready,
    input wire logic                         blank_tick,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic [eabb_pkg::PIXEL_W-1:0] smoothed_value,
    input wire logic                         row_end,
    input wire logic                         frame_end
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(smoothed_value)
                                    && $stable(row_end) && $stable(frame_end))
        else $error("result beat changed while stalled");

    // a pixel beat always starts a line-store pass, so input closes next cycle
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !blank_tick |=> !pix_ready)
        else $error("input still open after a pixel beat");

    // a new result is only loaded while the input side is busy
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!pix_ready))
        else $error("result appeared without work in flight");

    // output empty when leaving reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

endmodule

bind edge_aware_box_blur_3x3_top eabb_checker u_eabb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pixel.valid),
    .pix_ready      (pixel.ready),
    .blank_tick     (pixel.blank_tick),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .smoothed_value (result.smoothed_value),
    .row_end        (result.row_end),
    .frame_end      (result.frame_end)
);

`default_nettype wire
